// ----- design/ptw_pkg.sv -----
// Package with item types, walker state and constants for the page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

  // Entry bit positions.
  localparam int unsigned BitPresent  = 0;
  localparam int unsigned BitWritable = 1;
  localparam int unsigned BitUser     = 2;
  localparam int unsigned BitHuge     = 7;
  localparam int unsigned BitSwTable  = 9;
  localparam int unsigned BitSwMap    = 10;
  localparam int unsigned BitNx       = 63;

  // Base masks for 4K tables and pages, 2M pages and 1G pages.
  localparam logic [63:0] Mask4kBase = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] Mask2mBase = 64'h000f_ffff_ffe0_0000;
  localparam logic [63:0] Mask1gBase = 64'h000f_ffff_c000_0000;

  // Input item kinds.
  localparam logic KindTranslate = 1'b0;
  localparam logic KindResponse  = 1'b1;

  // Result item kinds.
  localparam logic ResultRead   = 1'b0;
  localparam logic ResultFinish = 1'b1;

  // Walk levels, from the top-level table down to the last level.
  localparam logic [1:0] LevelTop   = 2'd0;
  localparam logic [1:0] LevelOne   = 2'd1;
  localparam logic [1:0] LevelTwo   = 2'd2;
  localparam logic [1:0] LevelThree = 2'd3;

  // Page sizes.
  localparam logic [1:0] Size4k = 2'd0;
  localparam logic [1:0] Size2m = 2'd1;
  localparam logic [1:0] Size1g = 2'd2;

  typedef enum logic [2:0] {
    StatusOk         = 3'd0,
    StatusBadRoot    = 3'd1,
    StatusNotPresent = 3'd2,
    StatusBusy       = 3'd3,
    StatusNotEnabled = 3'd4
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [51:0] root_table_addr;
    logic [47:0] virt_addr;
    logic [63:0] read_data;
  } ptw_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [51:0] read_address;
    status_e     status;
    logic [51:0] phys_addr;
    logic [63:0] page_flags;
    logic [1:0]  pg_size;
  } ptw_out_t;

  typedef struct packed {
    logic        busy;
    logic [1:0]  level;
    logic [47:0] vaddr;
    logic [63:0] flags;
  } ptw_state_t;

endpackage

// ----- design/ptw_step.sv -----
// Combinational walk step: next walker state and the result item for one input item.
`timescale 1ns / 1ps

module ptw_step
  import ptw_pkg::*;
#(
  parameter int unsigned PhysAddrBits = 52
) (
  input  ptw_in_t    item_i,
  input  logic       enable_i,
  input  ptw_state_t state_i,
  output ptw_state_t state_o,
  output logic       push_o,
  output ptw_out_t   result_o
);

  localparam logic [63:0] PhysMask = (64'd1 << PhysAddrBits) - 64'd1;

  logic [63:0] entry;
  logic [63:0] folded;
  logic [63:0] public_flags;
  logic [63:0] next_base;
  logic [63:0] pa_1g;
  logic [63:0] pa_2m;
  logic [63:0] pa_4k;
  logic [8:0]  next_index;
  logic        root_bad;
  ptw_out_t    read_res;
  ptw_out_t    fin_res;

  assign entry = item_i.read_data;

  // Rights folding: writable and user must hold at every level, no-execute at any.
  always_comb begin
    folded              = entry;
    folded[BitWritable] = entry[BitWritable] & state_i.flags[BitWritable];
    folded[BitUser]     = entry[BitUser] & state_i.flags[BitUser];
    folded[BitNx]       = entry[BitNx] | state_i.flags[BitNx];
    public_flags             = folded;
    public_flags[BitSwTable] = 1'b0;
    public_flags[BitSwMap]   = 1'b0;
  end

  // Address candidates for the next table and for each page size.
  assign next_base = entry & Mask4kBase & PhysMask;
  assign pa_1g = ((entry & Mask1gBase) | {34'd0, state_i.vaddr[29:0]}) & PhysMask;
  assign pa_2m = ((entry & Mask2mBase) | {43'd0, state_i.vaddr[20:0]}) & PhysMask;
  assign pa_4k = ((entry & Mask4kBase) | {52'd0, state_i.vaddr[11:0]}) & PhysMask;

  // Table index for the read that follows the current level.
  always_comb begin
    unique case (state_i.level)
      LevelTop:   next_index = state_i.vaddr[38:30];
      LevelOne:   next_index = state_i.vaddr[29:21];
      LevelTwo:   next_index = state_i.vaddr[20:12];
      default:    next_index = 9'd0;
    endcase
  end

  assign root_bad = (item_i.root_table_addr == 52'd0) ||
                    (item_i.root_table_addr[11:0] != 12'd0) ||
                    ((item_i.root_table_addr & ~PhysMask[51:0]) != 52'd0);

  // Main decision for one input item.
  always_comb begin
    state_o  = state_i;
    push_o   = 1'b0;
    read_res = '0;
    fin_res  = '0;
    read_res.result_kind = ResultRead;
    read_res.status      = StatusOk;
    fin_res.result_kind  = ResultFinish;
    fin_res.status       = StatusOk;
    result_o = fin_res;

    if (item_i.kind == KindTranslate) begin
      push_o = 1'b1;
      if (state_i.busy) begin
        result_o.status = StatusBusy;
      end else if (!enable_i) begin
        result_o.status = StatusNotEnabled;
      end else if (root_bad) begin
        result_o.status = StatusBadRoot;
      end else begin
        state_o.busy  = 1'b1;
        state_o.level = LevelTop;
        state_o.vaddr = item_i.virt_addr;
        state_o.flags = '0;
        result_o = read_res;
        result_o.read_address = (item_i.root_table_addr |
                                 {40'd0, item_i.virt_addr[47:39], 3'd0}) &
                                PhysMask[51:0];
      end
    end else if (state_i.busy) begin
      push_o = 1'b1;
      if (!entry[BitPresent]) begin
        state_o.busy    = 1'b0;
        state_o.level   = LevelTop;
        result_o.status = StatusNotPresent;
      end else if (state_i.level == LevelTop) begin
        state_o.flags = entry;
        state_o.level = LevelOne;
        result_o = read_res;
        result_o.read_address = next_base[51:0] | {40'd0, next_index, 3'd0};
      end else begin
        state_o.flags = folded;
        if ((state_i.level == LevelOne) && entry[BitHuge]) begin
          state_o.busy = 1'b0;
          state_o.level = LevelTop;
          result_o.phys_addr  = pa_1g[51:0];
          result_o.page_flags = public_flags;
          result_o.pg_size    = Size1g;
        end else if ((state_i.level == LevelTwo) && entry[BitHuge]) begin
          state_o.busy = 1'b0;
          state_o.level = LevelTop;
          result_o.phys_addr  = pa_2m[51:0];
          result_o.page_flags = public_flags;
          result_o.pg_size    = Size2m;
        end else if (state_i.level == LevelThree) begin
          state_o.busy = 1'b0;
          state_o.level = LevelTop;
          result_o.phys_addr  = pa_4k[51:0];
          result_o.page_flags = public_flags;
          result_o.pg_size    = Size4k;
        end else begin
          state_o.level = state_i.level + 2'd1;
          result_o = read_res;
          result_o.read_address = next_base[51:0] | {40'd0, next_index, 3'd0};
        end
      end
    end
  end

endmodule

// ----- design/ptw_out_buf.sv -----
// Result register with a skid stage that catches one more item while the output stalls.
`timescale 1ns / 1ps

module ptw_out_buf
  import ptw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ptw_out_t push_data_i,
  output logic     space_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ptw_out_t out_data_o
);

  logic     out_valid_q;
  logic     skid_valid_q;
  ptw_out_t out_q;
  ptw_out_t skid_q;

  // New items are taken only while the skid stage is empty.
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control: head register and skid register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload follows the same decisions.
  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (!out_valid_q) begin
      if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// ----- design/page_table_walk_translate.sv -----
// Top level of the four-level page table walker, translate path only.
//
// Usage: the input channel (in_valid_i/in_ready_o/in_data_i) carries two
// kinds of item: a translate request with a root table address and a
// virtual address, or an entry word answering the last read request. The
// output channel (out_valid_o/out_ready_i/out_data_o) returns either the
// address of the next entry to read or a finished translation with status,
// physical address, effective flags and page size. A response that arrives
// while no walk is running produces no result. A request during a walk is
// answered at once with a busy reject and leaves the walk untouched.
// The enable register is written through cfg_valid_i/cfg_ready_o and is
// always ready; write it only while the walker is idle.
// A result is registered in the result register, or in the skid register on a stall.
// One item is accepted every cycle while the skid register is empty; the walk state is
// updated by a single level of logic between the state registers and the result register.
// When the receiver stalls, one extra item is caught in a skid register and
// the input side then stops until the output drains.
// Reset clears the walk state, the enable register and both result slots.
`timescale 1ns / 1ps

module page_table_walk_translate
  import ptw_pkg::*;
#(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_walker_enable_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ptw_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ptw_out_t out_data_o
);

  logic       enable_q;
  ptw_state_t state_q;
  ptw_state_t state_d;
  logic       step_push;
  ptw_out_t   step_result;
  logic       space;
  logic       in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign in_accept   = in_valid_i && space;

  // Enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_walker_enable_i;
    end
  end

  // Walk state advances on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  ptw_step #(
    .PhysAddrBits(PHYS_ADDR_BITS)
  ) u_step (
    .item_i   (in_data_i),
    .enable_i (enable_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .push_o   (step_push),
    .result_o (step_result)
  );

  ptw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && step_push),
    .push_data_i (step_result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
